[hw/rtl/u8d_pkg.sv]
// shared types and constants of the utf-8 stream decoder
package u8d_pkg;

  localparam int CP_W        = 21;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int QCW         = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_LEN1   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN3   = 21'h010000;

  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;
  } u8d_result_t;

  // results caused by one input word, handed from front to back
  typedef struct packed {
    logic [1:0]  cnt;
    u8d_result_t r0;
    u8d_result_t r1;
  } u8d_entry_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } u8d_qstat_t;

endpackage

[hw/rtl/u8d_byte_if.sv]
// input channel carrying one text byte per word
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[hw/rtl/u8d_cp_if.sv]
// output channel carrying one decoded code point per word
interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_item;

  modport source (output valid, output code_point, output replaced,
                  output last_of_item, input ready);
  modport sink   (input valid, input code_point, input replaced,
                  input last_of_item, output ready);
endinterface

[hw/rtl/u8d_front.sv]
// front end: accepts bytes, tracks the open sequence and forms result entries
module u8d_front (
  input  logic                clk,
  input  logic                rst,
  u8d_byte_if.sink            text,
  input  u8d_pkg::u8d_qstat_t qstat,
  output logic                push,
  output u8d_pkg::u8d_entry_t push_entry
);
  import u8d_pkg::*;

  typedef struct packed {
    logic            emit;
    u8d_result_t     res;
    logic [1:0]      due;
    logic [CP_W-1:0] part;
  } lead_t;

  logic [1:0]      bytes_due, bytes_due_next;
  logic [1:0]      sequence_length, sequence_length_next;
  logic [CP_W-1:0] partial_value, partial_value_next;
  logic            accept;
  logic [7:0]      b;
  lead_t           ld;
  logic [CP_W-1:0] shifted;
  logic [CP_W-1:0] minimum;
  logic            bad;

  // classify a byte seen with no sequence open
  function automatic lead_t lead_of(input logic [7:0] v);
    lead_t l;
    l.emit    = 1'b0;
    l.res.cp  = {{(CP_W-8){1'b0}}, v};
    l.res.rep = 1'b0;
    l.due     = 2'd0;
    l.part    = '0;
    if (v == 8'd0) begin
      l.emit = 1'b0;
    end else if (v < ASCII_END) begin
      l.emit = 1'b1;
    end else if (v >= LEAD2_LO && v <= LEAD2_HI) begin
      l.due  = 2'd1;
      l.part = {{(CP_W-5){1'b0}}, v[4:0]};
    end else if (v >= LEAD3_LO && v <= LEAD3_HI) begin
      l.due  = 2'd2;
      l.part = {{(CP_W-4){1'b0}}, v[3:0]};
    end else if (v >= LEAD4_LO && v <= LEAD4_HI) begin
      l.due  = 2'd3;
      l.part = {{(CP_W-3){1'b0}}, v[2:0]};
    end else begin
      l.emit    = 1'b1;
      l.res.cp  = REPL_CP;
      l.res.rep = 1'b1;
    end
    return l;
  endfunction

  assign text.ready = !qstat.full;
  assign accept     = text.valid && text.ready;
  assign b          = text.data_byte;
  assign ld         = lead_of(b);
  assign shifted    = {partial_value[CP_W-7:0], b[5:0]};

  // range check of a completed sequence
  always_comb begin
    case (sequence_length)
      2'd1:    minimum = MIN_LEN1;
      2'd2:    minimum = MIN_LEN2;
      default: minimum = MIN_LEN3;
    endcase
    bad = (shifted < minimum) || (shifted > MAX_SCALAR) ||
          (shifted >= SURR_LO && shifted <= SURR_HI);
  end

  // next state and the entry for this word
  always_comb begin
    bytes_due_next       = bytes_due;
    sequence_length_next = sequence_length;
    partial_value_next   = partial_value;
    push_entry.cnt       = 2'd0;
    push_entry.r0.cp     = REPL_CP;
    push_entry.r0.rep    = 1'b1;
    push_entry.r1        = ld.res;
    if (bytes_due == 2'd0) begin
      push_entry.r0        = ld.res;
      push_entry.cnt       = {1'b0, ld.emit};
      bytes_due_next       = ld.due;
      sequence_length_next = ld.due;
      partial_value_next   = ld.part;
    end else if (b == 8'd0) begin
      push_entry.cnt       = 2'd1;
      bytes_due_next       = 2'd0;
      sequence_length_next = 2'd0;
      partial_value_next   = '0;
    end else if (b[7:6] != CONT_TAG) begin
      // broken sequence, then the byte again as a new lead
      push_entry.cnt       = ld.emit ? 2'd2 : 2'd1;
      bytes_due_next       = ld.due;
      sequence_length_next = ld.due;
      partial_value_next   = ld.part;
    end else if (bytes_due == 2'd1) begin
      push_entry.cnt       = 2'd1;
      if (!bad) begin
        push_entry.r0.cp  = shifted;
        push_entry.r0.rep = 1'b0;
      end
      bytes_due_next       = 2'd0;
      sequence_length_next = 2'd0;
      partial_value_next   = '0;
    end else begin
      bytes_due_next       = bytes_due - 2'd1;
      partial_value_next   = shifted;
    end
  end

  assign push = accept && (push_entry.cnt != 2'd0);

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_due       <= 2'd0;
      sequence_length <= 2'd0;
      partial_value   <= '0;
    end else if (accept) begin
      bytes_due       <= bytes_due_next;
      sequence_length <= sequence_length_next;
      partial_value   <= partial_value_next;
    end
  end

  a_idle_no_len: assert property (@(posedge clk) disable iff (rst)
    bytes_due == 2'd0 |-> sequence_length == 2'd0)
    else $error("sequence length left over while idle");

  a_due_le_len: assert property (@(posedge clk) disable iff (rst)
    bytes_due <= sequence_length)
    else $error("more continuation bytes due than the sequence holds");

  a_bad_lead_idle: assert property (@(posedge clk) disable iff (rst)
    accept && bytes_due == 2'd0 && b > LEAD4_HI |=> bytes_due == 2'd0)
    else $error("bad lead opened a sequence");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("entry pushed into a full queue");

endmodule

[hw/rtl/u8d_queue.sv]
// short queue of result entries between front and back
module u8d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u8d_pkg::u8d_entry_t push_entry,
  input  logic                pop,
  output u8d_pkg::u8d_entry_t head,
  output u8d_pkg::u8d_qstat_t qstat
);
  import u8d_pkg::*;

  u8d_entry_t     mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign head            = mem[rd_ptr];
  assign qstat.full      = (count == QCW'(QDEPTH));
  assign qstat.not_empty = (count != '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> push_entry.cnt != 2'd0)
    else $error("entry without results queued");

endmodule

[hw/rtl/u8d_back.sv]
// back end: sends the one or two results of each entry through an output register
module u8d_back (
  input  logic                clk,
  input  logic                rst,
  input  u8d_pkg::u8d_entry_t head,
  input  u8d_pkg::u8d_qstat_t qstat,
  output logic                pop,
  u8d_cp_if.source            codes
);
  import u8d_pkg::*;

  logic        sub;
  logic        load;
  logic        last;
  u8d_result_t sel;
  logic        valid;
  u8d_result_t res;
  logic        res_last;

  assign load = qstat.not_empty && (!valid || codes.ready);
  assign sel  = sub ? head.r1 : head.r0;
  assign last = sub || (head.cnt == 2'd1);
  assign pop  = load && last;

  // output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sub   <= 1'b0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        sub   <= !last;
      end else if (codes.ready) begin
        valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res      <= sel;
      res_last <= last;
    end
  end

  assign codes.valid        = valid;
  assign codes.code_point   = res.cp;
  assign codes.replaced     = res.rep;
  assign codes.last_of_item = res_last;

  a_sub_pair: assert property (@(posedge clk) disable iff (rst)
    sub && qstat.not_empty |-> head.cnt == 2'd2)
    else $error("second result selected from a single-result entry");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    $rose(sub) |-> valid && !res_last)
    else $error("first of a pair marked last");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    valid && !codes.ready |=> valid && $stable(res) && $stable(res_last))
    else $error("output word changed while stalled");

endmodule

[hw/rtl/utf8_stream_decoder_core.sv]
// top level of the utf-8 stream decoder with replacement
// Takes one byte per cycle while the queue has room and returns Unicode code
// points, U+FFFD (replaced set) for malformed input; a zero byte ends the text
// and flushes an open sequence. Each accepted byte yields zero, one or two
// words; last_of_item marks the final word of a byte. The front end accepts a
// byte every cycle while its four-entry result queue has room; the back end
// sends one word per cycle from its output register while the receiver is
// ready, so a byte that yields two words sends them one after the other. A
// result passes from its byte through the result queue into the output register.
module utf8_stream_decoder_core (
  input  logic      clk,
  input  logic      rst,
  u8d_byte_if.sink  text,
  u8d_cp_if.source  codes
);
  import u8d_pkg::*;

  logic       push;
  logic       pop;
  u8d_entry_t push_entry;
  u8d_entry_t head;
  u8d_qstat_t qstat;

  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  u8d_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .codes (codes)
  );

endmodule
